// ===== src/crc24a_byte_stream_generator_defines.svh =====
// assertion macros for the crc-24a byte stream generator
`ifndef CRC24A_BYTE_STREAM_GENERATOR_DEFINES_SVH
`define CRC24A_BYTE_STREAM_GENERATOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define CRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/crc24a_pkg.sv =====
// types, constants and crc functions for the crc-24a byte stream generator
`default_nettype none

package crc24a_pkg;

  localparam int unsigned CRC_W    = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_BYTES = CRC_W / BYTE_W;
  localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic              end_flag;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_crc;
    logic              last_of_run;
  } out_beat_t;

  // eight serial crc steps, bit 0 of the byte first
  function automatic logic [CRC_W-1:0] crc_byte_update(
    input logic [CRC_W-1:0]  rem,
    input logic [BYTE_W-1:0] data
  );
    logic [CRC_W-1:0] r;
    logic             fb;
    r = rem;
    for (int j = 0; j < BYTE_W; j++) begin
      fb = r[CRC_W-1] ^ data[j];
      r  = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // crc byte k bit j holds remainder bit 23-8k-j; byte 0 in the low bits
  function automatic logic [CRC_W-1:0] crc_out_bytes(input logic [CRC_W-1:0] rem);
    logic [CRC_W-1:0] o;
    o = '0;
    for (int k = 0; k < CRC_BYTES; k++) begin
      for (int j = 0; j < BYTE_W; j++) begin
        o[k*BYTE_W + j] = rem[CRC_W-1 - k*BYTE_W - j];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== src/crc24a_byte_stream_generator.sv =====
// crc-24a byte stream generator: input skid register, crc update and output burst register
// an accepted beat is held in the skid register, then its result in the burst register
// throughput: one data byte per cycle unless out_stall; an end item yields 3 crc bytes
// the rate is set by the output burst register, which sends one byte per beat
// reset (rst_n low, synchronous) clears the remainder and empties both stages
`default_nettype none

module crc24a_byte_stream_generator
  import crc24a_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_beat
);

  `include "crc24a_byte_stream_generator_defines.svh"

  localparam int unsigned CNT_W = $clog2(CRC_BYTES + 1);

  logic                 s1_vld_r, s1_vld_nxt;
  logic [BYTE_W-1:0]    s1_byte_r;
  logic                 s1_end_r;
  logic [CNT_W-1:0]     ob_cnt_r, ob_cnt_nxt;
  logic [CRC_W-1:0]     ob_data_r, ob_data_nxt;
  logic                 ob_crc_r, ob_crc_nxt;
  logic [CRC_W-1:0]     rem_r, rem_nxt;

  logic in_fire, out_fire, ob_free, s1_move;

  assign out_valid = (ob_cnt_r != '0);
  assign out_fire  = out_valid & ~out_stall;
  assign ob_free   = (ob_cnt_r == '0) | ((ob_cnt_r == CNT_W'(1)) & out_fire);
  assign s1_move   = s1_vld_r & ob_free;
  assign in_stall  = s1_vld_r & ~s1_move;
  assign in_fire   = in_valid & ~in_stall;

  assign out_beat.out_byte    = ob_data_r[BYTE_W-1:0];
  assign out_beat.is_crc      = ob_crc_r;
  assign out_beat.last_of_run = (ob_cnt_r == CNT_W'(1));

  always_comb begin
    s1_vld_nxt  = in_fire | (s1_vld_r & ~s1_move);
    ob_cnt_nxt  = ob_cnt_r;
    ob_data_nxt = ob_data_r;
    ob_crc_nxt  = ob_crc_r;
    rem_nxt     = rem_r;
    if (s1_move) begin
      if (s1_end_r) begin
        ob_cnt_nxt  = CNT_W'(CRC_BYTES);
        ob_data_nxt = crc_out_bytes(rem_r);
        ob_crc_nxt  = 1'b1;
        rem_nxt     = '0;
      end else begin
        ob_cnt_nxt  = CNT_W'(1);
        ob_data_nxt = {{(CRC_W-BYTE_W){1'b0}}, s1_byte_r};
        ob_crc_nxt  = 1'b0;
        rem_nxt     = crc_byte_update(rem_r, s1_byte_r);
      end
    end else if (out_fire) begin
      ob_cnt_nxt  = ob_cnt_r - CNT_W'(1);
      ob_data_nxt = {{BYTE_W{1'b0}}, ob_data_r[CRC_W-1:BYTE_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      ob_cnt_r <= '0;
      rem_r    <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_beat.msg_byte;
      s1_end_r  <= in_beat.end_flag;
    end
    ob_data_r <= ob_data_nxt;
    ob_crc_r  <= ob_crc_nxt;
  end

  `CRC_ASSERT(a_stall_has_item, !in_stall || s1_vld_r, "stall without a held beat")
  `CRC_ASSERT_NEXT(a_crc_burst_whole, out_valid && out_beat.is_crc && !out_beat.last_of_run,
    out_valid && out_beat.is_crc, "crc burst broken")
  `CRC_ASSERT_NEXT(a_rem_cleared, s1_move && s1_end_r, rem_r == '0, "remainder not cleared")
  `CRC_ASSERT_NEXT(a_data_single, s1_move && !s1_end_r,
    out_valid && !out_beat.is_crc && out_beat.last_of_run, "data beat not single")

endmodule

`default_nettype wire
